// ===== sv/lc3_pkg.sv =====
// Shared types and constants for the LC-3 instruction execute core.
`timescale 1ns / 1ps
`default_nettype none

package lc3_pkg;

	// Word and field widths.
	localparam int WORD_BITS     = 16;
	localparam int REG_IDX_BITS  = 3;
	localparam int REG_COUNT     = 8;
	localparam int FLAG_BITS     = 3;
	localparam int CMD_BITS      = 4;
	localparam int ADDR_BITS_DEF = 16;

	// Stream payload widths, padded to whole bytes.
	localparam int IN_DATA_BITS  = 48;
	localparam int IN_USER_BITS  = 8;
	localparam int OUT_DATA_BITS = 80;

	// Condition flag codes.
	localparam logic [FLAG_BITS-1:0] FLAG_N = 3'd4;
	localparam logic [FLAG_BITS-1:0] FLAG_Z = 3'd2;
	localparam logic [FLAG_BITS-1:0] FLAG_P = 3'd1;

	// Trap vector that halts the machine, and the link register.
	localparam logic [7:0] HALT_VECTOR = 8'h25;
	localparam logic [REG_IDX_BITS-1:0] LINK_REG = 3'd7;

	// Command codes carried on the input selector.
	typedef enum logic [CMD_BITS-1:0] {
		CMD_BR      = 4'd0,
		CMD_ADD     = 4'd1,
		CMD_LD      = 4'd2,
		CMD_ST      = 4'd3,
		CMD_JSR     = 4'd4,
		CMD_AND     = 4'd5,
		CMD_LDR     = 4'd6,
		CMD_STR     = 4'd7,
		CMD_NOT     = 4'd8,
		CMD_LDI     = 4'd9,
		CMD_STI     = 4'd10,
		CMD_JMP     = 4'd11,
		CMD_LEA     = 4'd12,
		CMD_TRAP    = 4'd13,
		CMD_HOST_WR = 4'd14,
		CMD_SET_PC  = 4'd15
	} cmd_t;

	// Flags derived from a value written to a register.
	function automatic logic [FLAG_BITS-1:0] flags_of(input logic [WORD_BITS-1:0] v);
		logic [FLAG_BITS-1:0] f;
		if (v[WORD_BITS-1]) begin
			f = FLAG_N;
		end else if (v == '0) begin
			f = FLAG_Z;
		end else begin
			f = FLAG_P;
		end
		return f;
	endfunction

endpackage

`default_nettype wire

// ===== sv/lc3_instruction_execute_core.sv =====
// Top level of the LC-3 instruction execute core: sequencer, register file and word memory.
`timescale 1ns / 1ps
`default_nettype none

// A result is registered in the output register at the end of the execute phase, which follows
// two read phases on the register file and word memory read ports and waits while the output
// register is still full. A new input beat is taken only when idle or as the current item retires.
// Reset: registers read as zero (per-entry valid bits), PC is zero, flags show zero,
// halted is clear. Word memory content is not initialized; no clearing pass is needed.
module lc3_instruction_execute_core #(
	parameter int ADDR_BITS = lc3_pkg::ADDR_BITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// Input stream.
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	// [15:0] instruction, [31:16] host_address, [47:32] host_data
	input  wire logic [lc3_pkg::IN_DATA_BITS-1:0]  s_tdata,
	// [3:0] command, [7:4] zero
	input  wire logic [lc3_pkg::IN_USER_BITS-1:0]  s_tuser,
	// Result stream.
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	// [0] reg_written, [3:1] reg_index, [19:4] reg_value, [20] mem_written,
	// [36:21] mem_address, [52:37] mem_value, [68:53] program_counter,
	// [71:69] condition, [72] halted, [79:73] zero
	output logic [lc3_pkg::OUT_DATA_BITS-1:0]      m_tdata
);
	import lc3_pkg::*;

	localparam int MEM_WORDS = 1 << ADDR_BITS;

	typedef enum logic [1:0] {
		PH_READ_A,
		PH_READ_B,
		PH_EXEC
	} phase_t;

	// Sequencer and architectural state.
	phase_t                  ph_q;
	logic                    busy_q;
	cmd_t                    cmd_q;
	logic [WORD_BITS-1:0]    ins_q;
	logic [WORD_BITS-1:0]    haddr_q;
	logic [WORD_BITS-1:0]    hdata_q;
	logic [WORD_BITS-1:0]    pc_q;
	logic [FLAG_BITS-1:0]    flags_q;
	logic                    halt_q;
	logic [REG_COUNT-1:0]    reg_valid_q;
	logic                    out_valid_q;
	logic [OUT_DATA_BITS-1:0] out_data_q;
	logic [WORD_BITS-1:0]    reg_a_q;

	// Memories and their registered read data.
	logic [WORD_BITS-1:0]    rf_mem [REG_COUNT];
	logic [WORD_BITS-1:0]    rf_rdata_q;
	logic                    rf_rvalid_q;
	logic [WORD_BITS-1:0]    word_mem [MEM_WORDS];
	logic [WORD_BITS-1:0]    mem_rdata_q;

	// Decoded instruction fields.
	logic [REG_IDX_BITS-1:0] dr, sr1, sr2;
	logic [WORD_BITS-1:0]    off9, off6, imm5, off11;
	logic [WORD_BITS-1:0]    pc_off9;
	logic [WORD_BITS-1:0]    rf_out;
	logic [WORD_BITS-1:0]    ldr_addr;

	// Read port control.
	logic                    rd_en;
	logic [REG_IDX_BITS-1:0] rf_raddr;
	logic [ADDR_BITS-1:0]    mem_raddr;

	// Execute results.
	logic                    finish;
	logic                    rw, mw, setf;
	logic [REG_IDX_BITS-1:0] ridx;
	logic [WORD_BITS-1:0]    rval, mval, pc_nxt, op_b, mem_addr_full;
	logic [ADDR_BITS-1:0]    maddr;
	logic [FLAG_BITS-1:0]    flags_nxt;
	logic                    halt_nxt;

	assign dr      = ins_q[11:9];
	assign sr1     = ins_q[8:6];
	assign sr2     = ins_q[2:0];
	assign off9    = {{7{ins_q[8]}}, ins_q[8:0]};
	assign off6    = {{10{ins_q[5]}}, ins_q[5:0]};
	assign imm5    = {{11{ins_q[4]}}, ins_q[4:0]};
	assign off11   = {{5{ins_q[10]}}, ins_q[10:0]};
	assign pc_off9 = pc_q + off9;
	// A register never written since reset reads as zero.
	assign rf_out  = rf_rvalid_q ? rf_rdata_q : '0;
	// Base plus offset address for register-relative loads.
	assign ldr_addr = rf_out + off6;

	// Handshake: a new beat is taken when idle or in the cycle the current item retires.
	assign finish   = busy_q && (ph_q == PH_EXEC) && (!out_valid_q || m_tready);
	assign s_tready = !busy_q || finish;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// Read addresses: first phase fetches the base register and the PC-relative word,
	// second phase fetches the second operand and the dependent memory word.
	assign rd_en = busy_q && (ph_q != PH_EXEC);

	always_comb begin
		if (ph_q == PH_READ_A) begin
			rf_raddr  = sr1;
			mem_raddr = pc_off9[ADDR_BITS-1:0];
		end else begin
			rf_raddr = ((cmd_q == CMD_ADD) || (cmd_q == CMD_AND)) ? sr2 : dr;
			case (cmd_q)
				CMD_LDR: mem_raddr = ldr_addr[ADDR_BITS-1:0];
				CMD_LDI: mem_raddr = mem_rdata_q[ADDR_BITS-1:0];
				default: mem_raddr = pc_off9[ADDR_BITS-1:0];
			endcase
		end
	end

	// Execute phase: operands are reg_a_q (base), rf_out (second register) and mem_rdata_q.
	always_comb begin
		rw            = 1'b0;
		mw            = 1'b0;
		setf          = 1'b0;
		ridx          = '0;
		rval          = '0;
		mval          = '0;
		mem_addr_full = '0;
		pc_nxt        = pc_q;
		halt_nxt      = halt_q;
		op_b          = ins_q[5] ? imm5 : rf_out;
		case (cmd_q)
			CMD_BR: begin
				if ((dr & flags_q) != '0) begin
					pc_nxt = pc_off9;
				end
			end
			CMD_ADD: begin
				rw = 1'b1; setf = 1'b1; ridx = dr;
				rval = reg_a_q + op_b;
			end
			CMD_AND: begin
				rw = 1'b1; setf = 1'b1; ridx = dr;
				rval = reg_a_q & op_b;
			end
			CMD_LD, CMD_LDR, CMD_LDI: begin
				rw = 1'b1; setf = 1'b1; ridx = dr;
				rval = mem_rdata_q;
			end
			CMD_ST: begin
				mw = 1'b1; mem_addr_full = pc_off9; mval = rf_out;
			end
			CMD_STR: begin
				mw = 1'b1; mem_addr_full = reg_a_q + off6; mval = rf_out;
			end
			CMD_STI: begin
				mw = 1'b1; mem_addr_full = mem_rdata_q; mval = rf_out;
			end
			CMD_JSR: begin
				rw = 1'b1; ridx = LINK_REG; rval = pc_q;
				if (ins_q[11]) begin
					pc_nxt = pc_q + off11;
				end else if (sr1 == LINK_REG) begin
					// The link register is written before the base is read.
					pc_nxt = pc_q;
				end else begin
					pc_nxt = reg_a_q;
				end
			end
			CMD_NOT: begin
				rw = 1'b1; setf = 1'b1; ridx = dr;
				rval = ~reg_a_q;
			end
			CMD_JMP: begin
				pc_nxt = reg_a_q;
			end
			CMD_LEA: begin
				rw = 1'b1; setf = 1'b1; ridx = dr;
				rval = pc_off9;
			end
			CMD_TRAP: begin
				rw = 1'b1; ridx = LINK_REG; rval = pc_q;
				if (ins_q[7:0] == HALT_VECTOR) begin
					halt_nxt = 1'b1;
				end
			end
			CMD_HOST_WR: begin
				mw = 1'b1; mem_addr_full = haddr_q; mval = hdata_q;
			end
			CMD_SET_PC: begin
				pc_nxt = hdata_q;
			end
			default: begin
				pc_nxt = pc_q;
			end
		endcase
		maddr     = mem_addr_full[ADDR_BITS-1:0];
		flags_nxt = setf ? flags_of(rval) : flags_q;
	end

	// Sequencer, architectural state and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q        <= PH_READ_A;
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
			pc_q        <= '0;
			flags_q     <= FLAG_Z;
			halt_q      <= 1'b0;
			reg_valid_q <= '0;
		end else begin
			// The output beat stays until taken; a retiring item refills it.
			out_valid_q <= finish || (out_valid_q && !m_tready);
			if (finish) begin
				out_data_q  <= {7'd0, halt_nxt, flags_nxt, pc_nxt, mval,
					WORD_BITS'(maddr), mw, rval, ridx, rw};
				pc_q        <= pc_nxt;
				flags_q     <= flags_nxt;
				halt_q      <= halt_nxt;
				if (rw) begin
					reg_valid_q[ridx] <= 1'b1;
				end
			end
			if (ph_q == PH_READ_B) begin
				reg_a_q <= rf_out;
			end
			if (s_tvalid && s_tready) begin
				busy_q  <= 1'b1;
				ph_q    <= PH_READ_A;
				cmd_q   <= cmd_t'(s_tuser[CMD_BITS-1:0]);
				ins_q   <= s_tdata[15:0];
				haddr_q <= s_tdata[31:16];
				hdata_q <= s_tdata[47:32];
			end else if (finish) begin
				busy_q <= 1'b0;
				ph_q   <= PH_READ_A;
			end else if (busy_q && (ph_q == PH_READ_A)) begin
				ph_q <= PH_READ_B;
			end else if (busy_q && (ph_q == PH_READ_B)) begin
				ph_q <= PH_EXEC;
			end
		end
	end

	// Register file: one read port used in both read phases, written at retire.
	always_ff @(posedge clk) begin
		if (finish && rw) begin
			rf_mem[ridx] <= rval;
		end
		if (rd_en) begin
			rf_rdata_q  <= rf_mem[rf_raddr];
			rf_rvalid_q <= reg_valid_q[rf_raddr];
		end
	end

	// Word memory: reads in the two read phases, the write at retire.
	always_ff @(posedge clk) begin
		if (finish && mw) begin
			word_mem[maddr] <= mval;
		end
		if (rd_en) begin
			mem_rdata_q <= word_mem[mem_raddr];
		end
	end

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
// Self-checking testbench for the LC-3 instruction execute core.
`timescale 1ns / 1ps

module tb_top;
	import lc3_pkg::*;

	// Result beat as it sits on m_tdata, highest bits first.
	typedef struct packed {
		logic [6:0]  pad;
		logic        halted;
		logic [2:0]  cond;
		logic [15:0] pc;
		logic [15:0] mem_value;
		logic [15:0] mem_addr;
		logic        mem_wr;
		logic [15:0] reg_value;
		logic [2:0]  reg_idx;
		logic        reg_wr;
	} exec_result_t;

	// Tracks the architectural state and the results still owed by the core.
	class lc3_result_board;
		logic [15:0]  arch_regs [8];
		logic [15:0]  arch_pc;
		logic [2:0]   arch_cond;
		logic         arch_halted;
		logic [15:0]  arch_mem [bit [15:0]];
		exec_result_t expected_results [$];
		int           cmd_seen [16];
		int           err_count;
		int           checked;
		int           noted;

		function new();
			foreach (arch_regs[i]) arch_regs[i] = '0;
			foreach (cmd_seen[i]) cmd_seen[i] = 0;
			arch_pc = '0;
			arch_cond = FLAG_Z;
			arch_halted = 1'b0;
			err_count = 0;
			checked = 0;
			noted = 0;
		endfunction

		// A word never written reads as zero; the stimulus never relies on that.
		function logic [15:0] word_at(logic [15:0] a);
			return arch_mem.exists(a) ? arch_mem[a] : 16'h0000;
		endfunction

		task report(string what);
			err_count++;
			if (err_count <= 100) begin
				$display("mismatch %0d: %s", err_count, what);
			end
		endtask

		// Executes one accepted instruction beat and queues the result it must produce.
		function void note_instruction(cmd_t cmd, logic [15:0] ins, haddr, hdata);
			logic [2:0]   dr, sr1, sr2;
			logic [15:0]  off9, off6, imm5, off11, pc_now, operand;
			bit           set_flags;
			exec_result_t r;
			dr = ins[11:9];
			sr1 = ins[8:6];
			sr2 = ins[2:0];
			off9 = {{7{ins[8]}}, ins[8:0]};
			off6 = {{10{ins[5]}}, ins[5:0]};
			imm5 = {{11{ins[4]}}, ins[4:0]};
			off11 = {{5{ins[10]}}, ins[10:0]};
			pc_now = arch_pc;
			set_flags = 1'b0;
			r = '0;
			case (cmd)
				CMD_BR: begin
					if ((dr & arch_cond) != 3'b000) arch_pc = pc_now + off9;
				end
				CMD_ADD, CMD_AND: begin
					operand = ins[5] ? imm5 : arch_regs[sr2];
					r.reg_wr = 1'b1;
					r.reg_idx = dr;
					r.reg_value = (cmd == CMD_ADD) ? arch_regs[sr1] + operand
						: arch_regs[sr1] & operand;
					set_flags = 1'b1;
				end
				CMD_LD, CMD_LDR, CMD_LDI, CMD_NOT, CMD_LEA: begin
					r.reg_wr = 1'b1;
					r.reg_idx = dr;
					set_flags = 1'b1;
					case (cmd)
						CMD_LD:  r.reg_value = word_at(pc_now + off9);
						CMD_LDR: r.reg_value = word_at(arch_regs[sr1] + off6);
						CMD_LDI: r.reg_value = word_at(word_at(pc_now + off9));
						CMD_NOT: r.reg_value = ~arch_regs[sr1];
						default: r.reg_value = pc_now + off9;
					endcase
				end
				CMD_ST: begin
					r.mem_wr = 1'b1;
					r.mem_addr = pc_now + off9;
					r.mem_value = arch_regs[dr];
				end
				CMD_STR: begin
					r.mem_wr = 1'b1;
					r.mem_addr = arch_regs[sr1] + off6;
					r.mem_value = arch_regs[dr];
				end
				CMD_STI: begin
					r.mem_wr = 1'b1;
					r.mem_addr = word_at(pc_now + off9);
					r.mem_value = arch_regs[dr];
				end
				CMD_JSR: begin
					// The link register is written before the base is read.
					arch_regs[LINK_REG] = pc_now;
					r.reg_wr = 1'b1;
					r.reg_idx = LINK_REG;
					r.reg_value = pc_now;
					arch_pc = ins[11] ? pc_now + off11 : arch_regs[sr1];
				end
				CMD_JMP: begin
					arch_pc = arch_regs[sr1];
				end
				CMD_TRAP: begin
					r.reg_wr = 1'b1;
					r.reg_idx = LINK_REG;
					r.reg_value = pc_now;
					if (ins[7:0] == HALT_VECTOR) arch_halted = 1'b1;
				end
				CMD_HOST_WR: begin
					r.mem_wr = 1'b1;
					r.mem_addr = haddr;
					r.mem_value = hdata;
				end
				default: begin
					arch_pc = hdata;
				end
			endcase
			if (r.reg_wr) begin
				arch_regs[r.reg_idx] = r.reg_value;
				if (set_flags) begin
					arch_cond = r.reg_value[15] ? FLAG_N
						: (r.reg_value == 16'h0000) ? FLAG_Z : FLAG_P;
				end
			end
			if (r.mem_wr) arch_mem[r.mem_addr] = r.mem_value;
			r.pc = arch_pc;
			r.cond = arch_cond;
			r.halted = arch_halted;
			expected_results.push_back(r);
			cmd_seen[cmd]++;
			noted++;
		endfunction

		task compare(string field, logic [15:0] got, logic [15:0] want);
			if (got !== want) begin
				report($sformatf("result %0d %s: got %h, expected %h", checked, field, got, want));
			end
		endtask

		// Compares one result beat with the oldest expectation.
		task check_result(logic [OUT_DATA_BITS-1:0] data);
			exec_result_t got, want;
			got = exec_result_t'(data);
			checked++;
			if (expected_results.size() == 0) begin
				report($sformatf("result %0d arrived with nothing expected", checked));
				return;
			end
			want = expected_results.pop_front();
			compare("reg_written", 16'(got.reg_wr), 16'(want.reg_wr));
			compare("reg_index", 16'(got.reg_idx), 16'(want.reg_idx));
			compare("reg_value", got.reg_value, want.reg_value);
			compare("mem_written", 16'(got.mem_wr), 16'(want.mem_wr));
			compare("mem_address", got.mem_addr, want.mem_addr);
			compare("mem_value", got.mem_value, want.mem_value);
			compare("program_counter", got.pc, want.pc);
			compare("condition", 16'(got.cond), 16'(want.cond));
			compare("halted", 16'(got.halted), 16'(want.halted));
			compare("padding", 16'(got.pad), 16'h0000);
		endtask
	endclass

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     s_tvalid = 1'b0;
	logic                     s_tready;
	logic [IN_DATA_BITS-1:0]  s_tdata = '0;
	logic [IN_USER_BITS-1:0]  s_tuser = '0;
	logic                     m_tvalid;
	logic                     m_tready = 1'b0;
	logic [OUT_DATA_BITS-1:0] m_tdata;

	lc3_result_board board;
	int send_idle_pct = 22;
	int recv_idle_pct = 88;
	int beats_sent = 0;

	lc3_instruction_execute_core u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #4 clk = ~clk;

	// Receiver back-pressure changes on the falling edge.
	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Every result beat is checked at the edge that takes it.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) board.check_result(m_tdata);
	end

	// Drives one instruction beat, with random idle cycles ahead of it.
	task automatic send_beat(cmd_t cmd, logic [15:0] ins, haddr, hdata);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {hdata, haddr, ins};
		s_tuser <= {4'h0, cmd};
		do @(posedge clk); while (!s_tready);
		board.note_instruction(cmd, ins, haddr, hdata);
		beats_sent++;
		@(negedge clk);
	endtask

	// Fills a memory word through the host port unless it already holds data.
	task automatic make_readable(logic [15:0] a);
		if (!board.arch_mem.exists(a)) send_beat(CMD_HOST_WR, 16'($urandom), a, 16'($urandom));
	endtask

	// Sends an instruction after making sure every word it reads has been written.
	task automatic send_exec(cmd_t cmd, logic [15:0] ins, haddr, hdata);
		logic [15:0] a;
		a = board.arch_pc + {{7{ins[8]}}, ins[8:0]};
		case (cmd)
			CMD_LD, CMD_STI: make_readable(a);
			CMD_LDI: begin
				make_readable(a);
				make_readable(board.word_at(a));
			end
			CMD_LDR: make_readable(board.arch_regs[ins[8:6]] + {{10{ins[5]}}, ins[5:0]});
			default: ;
		endcase
		send_beat(cmd, ins, haddr, hdata);
	endtask

	task automatic send_op(cmd_t cmd, logic [15:0] ins);
		send_exec(cmd, ins, 16'($urandom), 16'($urandom));
	endtask

	// Mostly random instructions; a quarter are a store followed by a load of the same word.
	task automatic random_step();
		logic [15:0] ins_a, ins_b;
		ins_a = 16'($urandom);
		ins_b = 16'($urandom);
		if ($urandom_range(99) < 25) begin
			case ($urandom_range(2))
				0: begin
					send_op(CMD_ST, ins_a);
					send_op(CMD_LD, {ins_b[15:9], ins_a[8:0]});
				end
				1: begin
					send_op(CMD_STR, ins_a);
					send_op(CMD_LDR, {ins_b[15:9], ins_a[8:0]});
				end
				default: begin
					send_op(CMD_STI, ins_a);
					send_op(CMD_LDI, {ins_b[15:9], ins_a[8:0]});
				end
			endcase
		end else begin
			send_op(cmd_t'($urandom_range(15)), ins_a);
		end
	endtask

	// Directed corner cases; each instruction has its LC-3 opcode in the top four bits, host commands apart.
	task automatic directed_items();
		send_op(CMD_ADD, {4'h1, 3'd1, 3'd0, 1'b1, 5'h0F});
		send_op(CMD_ADD, {4'h1, 3'd2, 3'd0, 1'b1, 5'h10});
		send_op(CMD_AND, {4'h5, 3'd3, 3'd1, 1'b1, 5'h00});
		send_op(CMD_ADD, {4'h1, 3'd4, 3'd1, 3'b000, 3'd2});
		send_op(CMD_AND, {4'h5, 3'd5, 3'd4, 3'b000, 3'd1});
		send_op(CMD_NOT, {4'h9, 3'd6, 3'd0, 6'h3F});
		send_op(CMD_NOT, {4'h9, 3'd5, 3'd4, 6'h3F});
		// PC near the top so that offsets wrap.
		send_exec(CMD_SET_PC, 16'h0000, 16'h0000, 16'hFFF0);
		send_op(CMD_LEA, {4'hE, 3'd1, 9'h0FF});
		send_op(CMD_LEA, {4'hE, 3'd2, 9'h100});
		send_exec(CMD_HOST_WR, 16'hFFFF, 16'hFFFF, 16'h8000);
		send_exec(CMD_HOST_WR, 16'h0000, 16'h0000, 16'h7FFF);
		send_op(CMD_LD, {4'h2, 3'd3, 9'h00F});
		send_op(CMD_ST, {4'h3, 3'd6, 9'h0FF});
		send_op(CMD_STR, {4'h7, 3'd4, 3'd0, 6'h1F});
		send_op(CMD_LDR, {4'h6, 3'd7, 3'd0, 6'h20});
		send_op(CMD_STI, {4'hB, 3'd1, 9'h010});
		send_op(CMD_LDI, {4'hA, 3'd2, 9'h010});
		// Branch never taken, always taken, and on positive only.
		send_op(CMD_BR, {4'h0, 3'b000, 9'h0FF});
		send_op(CMD_BR, {4'h0, 3'b111, 9'h100});
		send_op(CMD_BR, {4'h0, 3'b001, 9'h001});
		send_op(CMD_JSR, {4'h4, 1'b1, 11'h3FF});
		send_op(CMD_JSR, {4'h4, 1'b1, 11'h400});
		// Subroutine call through the link register itself.
		send_op(CMD_JSR, {4'h4, 3'b000, 3'd7, 6'h00});
		send_op(CMD_JSR, {4'h4, 3'b000, 3'd3, 6'h00});
		send_op(CMD_JMP, {4'hC, 3'b000, 3'd7, 6'h00});
		send_op(CMD_TRAP, {4'hF, 4'h0, 8'h00});
		send_op(CMD_TRAP, {4'hF, 4'h0, 8'hFF});
		// Halt vector; execution carries on afterwards.
		send_op(CMD_TRAP, {4'hF, 4'h0, HALT_VECTOR});
	endtask

	initial begin
		int phase_end, waited, kinds;
		board = new();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		directed_items();
		// Three idling patterns: slow receiver, slow sender, then no idling at all.
		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 22 : (phase == 1) ? 88 : 0;
			recv_idle_pct = (phase == 0) ? 88 : (phase == 1) ? 22 : 0;
			phase_end = beats_sent + 250;
			while (beats_sent < phase_end) random_step();
		end
		s_tvalid <= 1'b0;
		waited = 0;
		while (board.expected_results.size() != 0 && waited < 100000) begin
			@(posedge clk);
			waited++;
		end
		repeat (12) @(posedge clk);
		if (board.expected_results.size() != 0) begin
			board.report($sformatf("%0d expected results never arrived",
				board.expected_results.size()));
		end
		kinds = 0;
		foreach (board.cmd_seen[i]) if (board.cmd_seen[i] > 0) kinds++;
		$display("Run covered %0d instruction beats over %0d of 16 commands.", board.noted, kinds);
		$display("Checked %0d result beats, %0d mismatches.", board.checked, board.err_count);
		if (board.err_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	// Hard stop in case the core stops moving beats.
	initial begin
		#5ms;
		$display("FAILURE");
		$finish;
	end

endmodule
